### src/c2d_pkg.sv
// Shared constants, types and register codes for the 3x3 convolution block.
// Used by the interfaces, the tap cells, the output queue, the top level and the checker.
// No dependencies.
package c2d_pkg;

    // Frame limits and kernel shape.
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int KS          = 3;
    localparam int TAPS        = KS * KS;

    // Counter widths follow the frame limits.
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int OROW_W      = $clog2(MAX_HEIGHT);
    localparam int IROW_W      = OROW_W + 1;

    // Configuration port.
    localparam int CFG_DIM_W   = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int WIDTH_RESET = 1024;
    localparam int HEIGHT_RESET = 1024;

    // Datapath widths.
    localparam int PIX_W       = 8;
    localparam int COEF_W      = 16;
    localparam int WORD_COEFS  = 4;
    localparam int PROD_W      = PIX_W + 1 + COEF_W;
    localparam int RSUM_W      = PROD_W + 2;
    localparam int SUM_W       = RSUM_W + 2;
    localparam int FRAC_W      = 8;
    localparam int OUT_W       = 20;

    // Output queue and pipeline timing.
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int RES_LATENCY = 5;

    typedef logic [PIX_W-1:0]              t_pix;
    typedef logic signed [COEF_W-1:0]      t_coef;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [RSUM_W-1:0]      t_rsum;
    typedef logic signed [SUM_W-1:0]       t_sum;
    typedef logic signed [OUT_W-1:0]       t_outpix;
    typedef logic [COL_W-1:0]              t_col;
    typedef logic [COL_W:0]                t_wdim;
    typedef logic [OROW_W-1:0]             t_orow;
    typedef logic [OROW_W:0]               t_hdim;
    typedef logic [IROW_W-1:0]             t_irow;
    typedef logic [CFG_DIM_W-1:0]          t_cfgdim;
    typedef logic [CFG_IDX_W-1:0]          t_cfgidx;
    typedef logic [CFG_DATA_W-1:0]         t_cfgdata;
    typedef logic [FIFO_AW-1:0]            t_fptr;
    typedef logic [FIFO_AW:0]              t_fcnt;
    typedef logic [FIFO_AW+1:0]            t_credit;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = CFG_IDX_W'(0),
        REG_HEIGHT = CFG_IDX_W'(1),
        REG_COEF_A = CFG_IDX_W'(2),
        REG_COEF_B = CFG_IDX_W'(3),
        REG_COEF_C = CFG_IDX_W'(4)
    } t_cfg_reg;

    // Per-cycle control handed to each tap cell.
    typedef struct packed {
        logic shift;
        logic calc;
        logic mask;
    } t_cell_ctl;

    // One result transaction.
    typedef struct packed {
        t_outpix pixel_out;
        logic    frame_last;
    } t_result;

endpackage

### src/c2d_if.sv
// Stream and configuration interfaces of the 3x3 convolution block.
// Depends on c2d_pkg for field types.

// Input pixel stream.
interface c2d_pix_if;
    logic              valid;
    logic              ready;
    c2d_pkg::t_pix     pixel_in;
    logic              flush;

    modport source (output valid, output pixel_in, output flush, input ready);
    modport sink   (input valid, input pixel_in, input flush, output ready);
endinterface

// Output result stream.
interface c2d_res_if;
    logic              valid;
    logic              ready;
    c2d_pkg::t_outpix  pixel_out;
    logic              frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

// Configuration write channel.
interface c2d_cfg_if;
    logic              valid;
    logic              ready;
    c2d_pkg::t_cfgidx  index;
    c2d_pkg::t_cfgdata data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### src/conv2d_same_zero_pad_top.sv
// 3x3 same-size convolution with zero padding on a raster pixel stream.
// Throughput: one transaction per cycle while queue credit lasts; nine tap cells, one
// multiplier each, keep pace. A result is released by the input transaction that
// comes one row plus one pixel after the result's own pixel.
// Reset (synchronous, active low) clears counters, window, pipeline, queue and registers
// to their defaults; the line stores are not cleared and need no clearing pass.
module conv2d_same_zero_pad_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    c2d_pix_if.sink   i_pix,
    c2d_cfg_if.sink   i_cfg,
    c2d_res_if.source o_res
);

    // Configuration registers.
    c2d_pkg::t_cfgdim  r_cfg_width;
    c2d_pkg::t_cfgdim  r_cfg_height;
    c2d_pkg::t_cfgdata r_coef_a;
    c2d_pkg::t_cfgdata r_coef_b;
    c2d_pkg::t_coef    r_coef_c;

    // Stream counters.
    c2d_pkg::t_col     r_in_col;
    c2d_pkg::t_irow    r_in_row;
    c2d_pkg::t_col     r_out_col;
    c2d_pkg::t_orow    r_out_row;

    // Stage 0 signals.
    c2d_pkg::t_wdim    w_dim;
    c2d_pkg::t_hdim    h_dim;
    logic              accept;
    c2d_pkg::t_pix     s0_pix;
    logic              s0_primed;
    logic              s0_last;
    logic              in_col_end;
    logic              out_col_end;
    logic              out_row_end;
    logic [c2d_pkg::KS-1:0]   row_ok;
    logic [c2d_pkg::KS-1:0]   col_ok;
    logic [c2d_pkg::TAPS-1:0] s0_mask;
    c2d_pkg::t_hdim    row_pos;
    c2d_pkg::t_wdim    col_pos;

    // Stage 1: line store read data arrives.
    logic              r1_valid;
    logic              r1_res;
    logic              r1_last;
    c2d_pkg::t_col     r1_col;
    c2d_pkg::t_pix     r1_pix;
    logic [c2d_pkg::TAPS-1:0] r1_mask;
    c2d_pkg::t_pix     ram1_q;
    c2d_pkg::t_pix     ram2_q;
    c2d_pkg::t_pix     above1;
    c2d_pkg::t_pix     above2;
    c2d_pkg::t_pix     edge_pix [c2d_pkg::KS];

    // Bypass of the most recent line store write.
    logic              r_fw_valid;
    c2d_pkg::t_col     r_fw_col;
    c2d_pkg::t_pix     r_fw_d1;
    c2d_pkg::t_pix     r_fw_d2;

    // Stage 2: tap cells form products.
    logic              r2_res;
    logic              r2_last;
    logic [c2d_pkg::TAPS-1:0] r2_mask;
    c2d_pkg::t_cell_ctl cell_ctl [c2d_pkg::TAPS];
    c2d_pkg::t_coef    coef     [c2d_pkg::TAPS];
    c2d_pkg::t_pix     win_pix  [c2d_pkg::TAPS];
    c2d_pkg::t_prod    prod     [c2d_pkg::TAPS];

    // Stage 3 and 4: row sums, then the total.
    logic              r3_res;
    logic              r3_last;
    logic              r4_res;
    logic              r4_last;
    c2d_pkg::t_rsum    r4_rsum  [c2d_pkg::KS];
    c2d_pkg::t_rsum    n_rsum   [c2d_pkg::KS];
    c2d_pkg::t_sum     total;
    c2d_pkg::t_result  push_data;

    // Output queue and credit.
    c2d_pkg::t_result  fifo_data;
    c2d_pkg::t_fcnt    fifo_count;
    c2d_pkg::t_credit  credit_used;

    // Configuration writes; unknown indexes are ignored.
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= c2d_pkg::t_cfgdim'(c2d_pkg::WIDTH_RESET);
            r_cfg_height <= c2d_pkg::t_cfgdim'(c2d_pkg::HEIGHT_RESET);
            r_coef_a     <= '0;
            r_coef_b     <= '0;
            r_coef_c     <= '0;
        end else if (i_cfg.valid) begin
            case (c2d_pkg::t_cfg_reg'(i_cfg.index))
                c2d_pkg::REG_WIDTH: begin
                    r_cfg_width <= i_cfg.data[c2d_pkg::CFG_DIM_W-1:0];
                end
                c2d_pkg::REG_HEIGHT: begin
                    r_cfg_height <= i_cfg.data[c2d_pkg::CFG_DIM_W-1:0];
                end
                c2d_pkg::REG_COEF_A: begin
                    r_coef_a <= i_cfg.data;
                end
                c2d_pkg::REG_COEF_B: begin
                    r_coef_b <= i_cfg.data;
                end
                c2d_pkg::REG_COEF_C: begin
                    r_coef_c <= c2d_pkg::t_coef'(i_cfg.data[c2d_pkg::COEF_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp the frame size: zero acts as one, oversize acts as the maximum.
    always_comb begin
        if (r_cfg_width == '0) begin
            w_dim = c2d_pkg::t_wdim'(1);
        end else if (32'(r_cfg_width) > 32'(c2d_pkg::MAX_WIDTH)) begin
            w_dim = c2d_pkg::t_wdim'(c2d_pkg::MAX_WIDTH);
        end else begin
            w_dim = c2d_pkg::t_wdim'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            h_dim = c2d_pkg::t_hdim'(1);
        end else if (32'(r_cfg_height) > 32'(c2d_pkg::MAX_HEIGHT)) begin
            h_dim = c2d_pkg::t_hdim'(c2d_pkg::MAX_HEIGHT);
        end else begin
            h_dim = c2d_pkg::t_hdim'(r_cfg_height);
        end
    end

    // Coefficients unpacked from the three words, row-major.
    always_comb begin
        for (int k = 0; k < c2d_pkg::TAPS; k++) begin
            if (k < c2d_pkg::WORD_COEFS) begin
                coef[k] = c2d_pkg::t_coef'(r_coef_a[k*c2d_pkg::COEF_W +: c2d_pkg::COEF_W]);
            end else if (k < 2 * c2d_pkg::WORD_COEFS) begin
                coef[k] = c2d_pkg::t_coef'(
                    r_coef_b[(k-c2d_pkg::WORD_COEFS)*c2d_pkg::COEF_W +: c2d_pkg::COEF_W]);
            end else begin
                coef[k] = r_coef_c;
            end
        end
    end

    // Credit: never accept more than the queue can absorb with what is in flight.
    always_comb begin
        credit_used = c2d_pkg::t_credit'(fifo_count) + c2d_pkg::t_credit'(r1_res)
                    + c2d_pkg::t_credit'(r2_res) + c2d_pkg::t_credit'(r3_res)
                    + c2d_pkg::t_credit'(r4_res);
    end

    assign i_pix.ready = i_rst_n && (credit_used < c2d_pkg::t_credit'(c2d_pkg::FIFO_DEPTH));
    assign accept      = i_pix.valid && i_pix.ready;

    // Stage 0: decide whether this transaction releases a result, and where it lies.
    always_comb begin
        s0_pix      = i_pix.flush ? '0 : i_pix.pixel_in;
        s0_primed   = (r_in_row >= c2d_pkg::t_irow'(2))
                   || ((r_in_row == c2d_pkg::t_irow'(1)) && (r_in_col != '0));
        in_col_end  = (c2d_pkg::t_wdim'(r_in_col) + c2d_pkg::t_wdim'(1)) >= w_dim;
        out_col_end = (c2d_pkg::t_wdim'(r_out_col) + c2d_pkg::t_wdim'(1)) >= w_dim;
        out_row_end = (c2d_pkg::t_hdim'(r_out_row) + c2d_pkg::t_hdim'(1)) >= h_dim;
        s0_last     = s0_primed && out_row_end && out_col_end;
    end

    // Tap masks: a tap row or column counts when its position lies inside the image.
    always_comb begin
        for (int r = 0; r < c2d_pkg::KS; r++) begin
            row_pos   = c2d_pkg::t_hdim'(r_out_row) + c2d_pkg::t_hdim'(r);
            row_ok[r] = (row_pos != '0) && (row_pos <= h_dim);
        end
        for (int c = 0; c < c2d_pkg::KS; c++) begin
            col_pos   = c2d_pkg::t_wdim'(r_out_col) + c2d_pkg::t_wdim'(c);
            col_ok[c] = (col_pos != '0) && (col_pos <= w_dim);
        end
        for (int r = 0; r < c2d_pkg::KS; r++) begin
            for (int c = 0; c < c2d_pkg::KS; c++) begin
                s0_mask[r*c2d_pkg::KS + c] = row_ok[r] && col_ok[c];
            end
        end
    end

    // Input and output position counters; the last result of a frame clears all four.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (accept) begin
            if (s0_last) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (s0_primed) begin
                    if (out_col_end) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + c2d_pkg::t_orow'(1);
                    end else begin
                        r_out_col <= r_out_col + c2d_pkg::t_col'(1);
                    end
                end
                if (in_col_end) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + c2d_pkg::t_irow'(1);
                end else begin
                    r_in_col <= r_in_col + c2d_pkg::t_col'(1);
                end
            end
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r1_res   <= 1'b0;
            r2_res   <= 1'b0;
            r3_res   <= 1'b0;
            r4_res   <= 1'b0;
        end else begin
            r1_valid <= accept;
            r1_res   <= accept && s0_primed;
            r2_res   <= r1_res;
            r3_res   <= r2_res;
            r4_res   <= r3_res;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        r1_last <= s0_last;
        r1_col  <= r_in_col;
        r1_pix  <= s0_pix;
        r1_mask <= s0_mask;
        r2_last <= r1_last;
        r2_mask <= r1_mask;
        r3_last <= r2_last;
        r4_last <= r3_last;
        r4_rsum <= n_rsum;
    end

    // Line stores: the row above and the row two above, indexed by column.
    c2d_ram #(
        .WIDTH (c2d_pkg::PIX_W),
        .DEPTH (c2d_pkg::MAX_WIDTH)
    ) u_line1 (
        .i_clk   (i_clk),
        .i_we    (r1_valid),
        .i_waddr (r1_col),
        .i_wdata (r1_pix),
        .i_re    (accept),
        .i_raddr (r_in_col),
        .o_rdata (ram1_q)
    );

    c2d_ram #(
        .WIDTH (c2d_pkg::PIX_W),
        .DEPTH (c2d_pkg::MAX_WIDTH)
    ) u_line2 (
        .i_clk   (i_clk),
        .i_we    (r1_valid),
        .i_waddr (r1_col),
        .i_wdata (above1),
        .i_re    (accept),
        .i_raddr (r_in_col),
        .o_rdata (ram2_q)
    );

    // A read issued in the same cycle as a write to the same column sees stale data,
    // so the last written values are forwarded on a column match.
    always_comb begin
        if (r_fw_valid && (r_fw_col == r1_col)) begin
            above1 = r_fw_d1;
            above2 = r_fw_d2;
        end else begin
            above1 = ram1_q;
            above2 = ram2_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else if (r1_valid) begin
            r_fw_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r1_valid) begin
            r_fw_col <= r1_col;
            r_fw_d1  <= r1_pix;
            r_fw_d2  <= above1;
        end
    end

    // New right-hand column of the window, top to bottom.
    always_comb begin
        edge_pix[0] = above2;
        edge_pix[1] = above1;
        edge_pix[2] = r1_pix;
    end

    // Control for the tap cells.
    always_comb begin
        for (int k = 0; k < c2d_pkg::TAPS; k++) begin
            cell_ctl[k].shift = r1_valid;
            cell_ctl[k].calc  = r2_res;
            cell_ctl[k].mask  = r2_mask[k];
        end
    end

    // Window: each row is a chain of cells that shifts toward the left.
    for (genvar gr = 0; gr < c2d_pkg::KS; gr++) begin : g_row
        for (genvar gc = 0; gc < c2d_pkg::KS; gc++) begin : g_col
            c2d_pkg::t_pix cell_in;
            if (gc == c2d_pkg::KS - 1) begin : g_edge
                assign cell_in = edge_pix[gr];
            end else begin : g_inner
                assign cell_in = win_pix[gr*c2d_pkg::KS + gc + 1];
            end
            c2d_tap_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (cell_ctl[gr*c2d_pkg::KS + gc]),
                .i_pix   (cell_in),
                .i_coef  (coef[gr*c2d_pkg::KS + gc]),
                .o_pix   (win_pix[gr*c2d_pkg::KS + gc]),
                .o_prod  (prod[gr*c2d_pkg::KS + gc])
            );
        end
    end

    // Stage 3: one sum per window row.
    always_comb begin
        for (int r = 0; r < c2d_pkg::KS; r++) begin
            n_rsum[r] = c2d_pkg::t_rsum'(prod[r*c2d_pkg::KS])
                      + c2d_pkg::t_rsum'(prod[r*c2d_pkg::KS + 1])
                      + c2d_pkg::t_rsum'(prod[r*c2d_pkg::KS + 2]);
        end
    end

    // Stage 4: total and floor shift by the fraction bits.
    always_comb begin
        total = c2d_pkg::t_sum'(r4_rsum[0]) + c2d_pkg::t_sum'(r4_rsum[1])
              + c2d_pkg::t_sum'(r4_rsum[2]);
        push_data.pixel_out  = c2d_pkg::t_outpix'(
            total[c2d_pkg::FRAC_W + c2d_pkg::OUT_W - 1 : c2d_pkg::FRAC_W]);
        push_data.frame_last = r4_last;
    end

    c2d_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r4_res),
        .i_data  (push_data),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (fifo_data),
        .o_count (fifo_count)
    );

    assign o_res.pixel_out  = fifo_data.pixel_out;
    assign o_res.frame_last = fifo_data.frame_last;

endmodule

### src/c2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the two line stores.
module c2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/c2d_tap_cell.sv
// One window tap: holds a pixel, passes it to its left neighbor, and forms
// the masked product with its coefficient. Depends on c2d_pkg.
module c2d_tap_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  c2d_pkg::t_cell_ctl i_ctl,
    input  c2d_pkg::t_pix      i_pix,
    input  c2d_pkg::t_coef     i_coef,
    output c2d_pkg::t_pix      o_pix,
    output c2d_pkg::t_prod     o_prod
);

    c2d_pkg::t_pix  r_pix;
    c2d_pkg::t_prod r_prod;
    c2d_pkg::t_prod n_prod;

    // The held pixel moves one place along the row on every shift.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix <= '0;
        end else if (i_ctl.shift) begin
            r_pix <= i_pix;
        end
    end

    // Unsigned pixel times signed coefficient, both extended to the product width.
    always_comb begin
        n_prod = c2d_pkg::t_prod'(signed'({1'b0, r_pix})) * c2d_pkg::t_prod'(i_coef);
    end

    // Taps outside the image contribute zero.
    always_ff @(posedge i_clk) begin
        if (i_ctl.calc) begin
            r_prod <= i_ctl.mask ? n_prod : '0;
        end
    end

    assign o_pix  = r_pix;
    assign o_prod = r_prod;

endmodule

### src/c2d_out_fifo.sv
// Small result queue that decouples the convolution pipeline from the output stream.
// Depends on c2d_pkg for the result type and depth.
module c2d_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  c2d_pkg::t_result i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output c2d_pkg::t_result o_data,
    output c2d_pkg::t_fcnt   o_count
);

    c2d_pkg::t_result r_mem [c2d_pkg::FIFO_DEPTH];
    c2d_pkg::t_fptr   r_wr_ptr;
    c2d_pkg::t_fptr   r_rd_ptr;
    c2d_pkg::t_fcnt   r_count;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    // Entry storage; the upstream credit check keeps pushes off a full queue.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + c2d_pkg::t_fptr'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + c2d_pkg::t_fptr'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + c2d_pkg::t_fcnt'(1);
            end else if (pop && !i_push) begin
                r_count <= r_count - c2d_pkg::t_fcnt'(1);
            end
        end
    end

endmodule

### src/c2d_checker.sv
// Port-level checks for the 3x3 convolution top level, bound to it below.
// Depends on c2d_pkg for the result latency and types.
module c2d_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_pix_valid,
    input logic             i_pix_ready,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input c2d_pkg::t_outpix i_res_pixel_out,
    input logic             i_res_frame_last
);

    // Reset empties the result queue.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // A stalled result holds its payload.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_res_pixel_out) && $stable(i_res_frame_last))
        else $error("stalled result changed");

    // A result appearing on an empty output follows its releasing transaction
    // by the fixed pipeline latency.
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(i_pix_valid && i_pix_ready, c2d_pkg::RES_LATENCY))
        else $error("result without a transaction at pipeline latency");

    // With nothing waiting at the output, the input side is never held off.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid |-> i_pix_ready)
        else $error("input stalled while output is empty");

endmodule

bind conv2d_same_zero_pad_top c2d_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_pix_valid      (i_pix.valid),
    .i_pix_ready      (i_pix.ready),
    .i_res_valid      (o_res.valid),
    .i_res_ready      (o_res.ready),
    .i_res_pixel_out  (o_res.pixel_out),
    .i_res_frame_last (o_res.frame_last)
);

### bench/tb.sv
// Self-checking testbench for the 3x3 zero-padded convolution block.
// Streams frames through the pixel channel and predicts every result in a model of its own.
// Depends on c2d_pkg, the stream interfaces in c2d_if and conv2d_same_zero_pad_top.
module tb;
    import c2d_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 4 * RES_LATENCY + 8;
    localparam int RANDOM_BUDGET = 1100;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        t_pix value;
        logic flush;
    } t_stream_item;

    // Clock, reset and channels.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always #6 i_clk = ~i_clk;

    c2d_pix_if pix_if ();
    c2d_res_if res_if ();
    c2d_cfg_if cfg_if ();

    conv2d_same_zero_pad_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // Drive state, known from time zero.
    logic     pix_valid_q = 1'b0;
    t_pix     pix_data_q  = '0;
    logic     pix_flush_q = 1'b0;
    logic     pix_taken   = 1'b0;
    logic     cfg_valid_q = 1'b0;
    t_cfgidx  cfg_index_q = '0;
    t_cfgdata cfg_data_q  = '0;
    logic     res_ready_q = 1'b0;

    assign pix_if.valid    = pix_valid_q;
    assign pix_if.pixel_in = pix_data_q;
    assign pix_if.flush    = pix_flush_q;
    assign cfg_if.valid    = cfg_valid_q;
    assign cfg_if.index    = cfg_index_q;
    assign cfg_if.data     = cfg_data_q;
    assign res_if.ready    = res_ready_q;

    // Stimulus bookkeeping.
    t_stream_item pending_pixels[$];
    t_stream_item next_item;
    t_result      expected_pixels[$];
    int items_queued    = 0;
    int accepted_count  = 0;
    int cfg_count       = 0;
    int results_checked = 0;
    int frames_seen     = 0;
    int mismatch_count  = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_requests   = 0;
    int holds_started   = 0;
    int hold_left       = 0;
    int cycle_count     = 0;
    int frame_w         = 1;
    int frame_h         = 1;
    int widest_frame    = 1;

    // Predictor state: registers, line stores, window and counters.
    t_cfgdim  width_reg  = t_cfgdim'(WIDTH_RESET);
    t_cfgdim  height_reg = t_cfgdim'(HEIGHT_RESET);
    t_cfgdata coef_a_reg = '0;
    t_cfgdata coef_b_reg = '0;
    logic [COEF_W-1:0] coef_c_reg = '0;
    t_pix line_mem [0:2*MAX_WIDTH-1];
    t_pix win [0:TAPS-1];
    int in_col  = 0;
    int in_row  = 0;
    int out_col = 0;
    int out_row = 0;

    initial begin
        foreach (line_mem[i]) line_mem[i] = '0;
        foreach (win[i]) win[i] = '0;
    end

    // Out-of-range sizes fold onto the nearest legal one.
    function automatic int clamp_dim(input int v, input int mx);
        if (v == 0) return 1;
        if (v > mx) return mx;
        return v;
    endfunction

    function automatic t_coef kernel_coef(input int k);
        logic [COEF_W-1:0] raw;
        if (k < WORD_COEFS) raw = coef_a_reg[COEF_W*k +: COEF_W];
        else if (k < 2 * WORD_COEFS) raw = coef_b_reg[COEF_W*(k-WORD_COEFS) +: COEF_W];
        else raw = coef_c_reg;
        return t_coef'(raw);
    endfunction

    task automatic apply_register(input t_cfgidx idx, input t_cfgdata d);
        case (idx)
            REG_WIDTH:  width_reg = d[CFG_DIM_W-1:0];
            REG_HEIGHT: height_reg = d[CFG_DIM_W-1:0];
            REG_COEF_A: coef_a_reg = d;
            REG_COEF_B: coef_b_reg = d;
            REG_COEF_C: coef_c_reg = d[COEF_W-1:0];
            default: ;
        endcase
    endtask

    // Advance the window by one pixel and predict the result it releases, if any.
    task automatic convolve_step(input t_pix pix, input logic is_flush);
        int w, h, col, tr, tc, r, c;
        t_pix v, above1, above2;
        bit primed, at_end;
        longint acc;
        t_result res;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        v = is_flush ? '0 : pix;
        col = in_col % MAX_WIDTH;
        above1 = line_mem[col];
        above2 = line_mem[MAX_WIDTH + col];
        primed = (in_row >= 2) || (in_row == 1 && in_col >= 1);
        line_mem[MAX_WIDTH + col] = above1;
        line_mem[col] = v;
        for (r = 0; r < KS; r++)
            for (c = 0; c < KS - 1; c++)
                win[r*KS + c] = win[r*KS + c + 1];
        win[KS - 1] = above2;
        win[2*KS - 1] = above1;
        win[3*KS - 1] = v;

        if (primed) begin
            acc = 0;
            for (r = 0; r < KS; r++) begin
                tr = out_row + r - 1;
                if (tr >= 0 && tr < h) begin
                    for (c = 0; c < KS; c++) begin
                        tc = out_col + c - 1;
                        if (tc >= 0 && tc < w)
                            acc += longint'(win[r*KS + c]) * longint'(kernel_coef(r*KS + c));
                    end
                end
            end
            at_end = (out_row + 1 >= h) && (out_col + 1 >= w);
            res.pixel_out = t_outpix'(acc >>> FRAC_W);
            res.frame_last = at_end;
            expected_pixels.push_back(res);
            if (at_end) begin
                in_col = 0;
                in_row = 0;
                out_col = 0;
                out_row = 0;
                return;
            end
            if (out_col + 1 >= w) begin
                out_col = 0;
                out_row = (out_row + 1) & 'h3FF;
            end else begin
                out_col = (out_col + 1) & 'h3FF;
            end
        end

        if (in_col + 1 >= w) begin
            in_col = 0;
            in_row = (in_row + 1) & 'h7FF;
        end else begin
            in_col = (in_col + 1) & 'h3FF;
        end
    endtask

    task automatic log_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // Compare one result transaction with the oldest prediction.
    task automatic check_result(input t_outpix got_pix, input logic got_last);
        t_result want;
        if (expected_pixels.size() == 0) begin
            log_mismatch($sformatf("unexpected result pixel_out %0d frame_last %0b",
                                   got_pix, got_last));
        end else begin
            want = expected_pixels.pop_front();
            results_checked++;
            if (want.frame_last) frames_seen++;
            if (want.pixel_out !== got_pix || want.frame_last !== got_last)
                log_mismatch($sformatf("pixel_out exp %0d got %0d, frame_last exp %0b got %0b",
                                       want.pixel_out, got_pix, want.frame_last, got_last));
        end
    endtask

    // Sample all channels at the rising edge.
    always @(posedge i_clk) begin
        pix_taken <= pix_valid_q && pix_if.ready;
        if (i_rst_n) begin
            if (cfg_valid_q && cfg_if.ready) begin
                apply_register(cfg_index_q, cfg_data_q);
                cfg_count <= cfg_count + 1;
            end
            if (pix_valid_q && pix_if.ready) begin
                convolve_step(pix_data_q, pix_flush_q);
                accepted_count++;
            end
            if (res_if.valid && res_ready_q)
                check_result(res_if.pixel_out, res_if.frame_last);
        end
    end

    // Pixel driver: holds a transaction until it is taken, idles at random between them.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pix_valid_q <= 1'b0;
        end else if (!pix_valid_q || pix_taken) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item = pending_pixels.pop_front();
                pix_valid_q <= 1'b1;
                pix_data_q <= next_item.value;
                pix_flush_q <= next_item.flush;
            end else begin
                pix_valid_q <= 1'b0;
            end
        end
    end

    // Result receiver: random back-pressure, plus long holds on request.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            res_ready_q <= 1'b0;
        end else if (hold_requests != holds_started) begin
            holds_started <= holds_started + 1;
            hold_left <= HOLD_CYCLES;
            res_ready_q <= 1'b0;
        end else begin
            res_ready_q <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic push_item(input t_pix value, input logic flush);
        t_stream_item it;
        it.value = value;
        it.flush = flush;
        pending_pixels.push_back(it);
        items_queued++;
    endtask

    // Queue items [from, upto) of a w x h frame; the tail past w*h is the drain sequence.
    task automatic queue_items(input int w, input int h, input int from, input int upto,
                               input bit noisy);
        int i;
        for (i = from; i < upto; i++) begin
            if (i < w * h)
                push_item(t_pix'($urandom), noisy && $urandom_range(11) == 0);
            else
                push_item(t_pix'($urandom), !(noisy && $urandom_range(2) == 0));
        end
    endtask

    // Write one register and wait for the transaction to be taken.
    task automatic write_reg(input t_cfgidx idx, input t_cfgdata val);
        int target;
        target = cfg_count + 1;
        @(negedge i_clk);
        cfg_valid_q <= 1'b1;
        cfg_index_q <= idx;
        cfg_data_q <= val;
        do @(negedge i_clk); while (cfg_count != target);
        cfg_valid_q <= 1'b0;
    endtask

    // Frame size writes carry random upper bits, which the block must drop.
    task automatic set_frame(input int wraw, input int hraw);
        t_cfgdata d;
        d = {$urandom, $urandom};
        d[CFG_DIM_W-1:0] = t_cfgdim'(wraw);
        write_reg(REG_WIDTH, d);
        d = {$urandom, $urandom};
        d[CFG_DIM_W-1:0] = t_cfgdim'(hraw);
        write_reg(REG_HEIGHT, d);
        frame_w = clamp_dim(wraw, MAX_WIDTH);
        frame_h = clamp_dim(hraw, MAX_HEIGHT);
        if (frame_w > widest_frame) widest_frame = frame_w;
    endtask

    task automatic write_kernel(input t_cfgdata a, input t_cfgdata b, input t_coef c,
                                input logic [2:0] which);
        t_cfgdata d;
        if (which[0]) write_reg(REG_COEF_A, a);
        if (which[1]) write_reg(REG_COEF_B, b);
        if (which[2]) begin
            d = {$urandom, $urandom};
            d[COEF_W-1:0] = c;
            write_reg(REG_COEF_C, d);
        end
    endtask

    function automatic t_cfgdata coef_word();
        case ($urandom_range(7))
            0: return {WORD_COEFS{16'h7FFF}};
            1: return {WORD_COEFS{16'h8000}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Wait until every transaction is in and every result is out, then let the pipeline settle.
    task automatic drain();
        while (accepted_count != items_queued || expected_pixels.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Test sequence.
    initial begin
        int f, nframes, total, split, mode, random_items;
        bit noisy, pressure_done;
        random_items = 0;
        pressure_done = 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 69;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero sizes act as a single pixel; largest positive kernel, a pixel where a flush is due.
        set_frame(0, 0);
        write_kernel({WORD_COEFS{16'h7FFF}}, {WORD_COEFS{16'h7FFF}}, 16'h7FFF, 3'b111);
        write_reg(t_cfgidx'($urandom_range(2**CFG_IDX_W - 1, int'(REG_COEF_C) + 1)),
                  {$urandom, $urandom});
        push_item(8'hFF, 1'b0);
        push_item(8'hAA, 1'b0);
        push_item(8'h00, 1'b1);
        drain();

        // Most negative kernel on full-scale pixels, with a flush inside the frame.
        set_frame(3, 2);
        write_kernel({WORD_COEFS{16'h8000}}, {WORD_COEFS{16'h8000}}, 16'h8000, 3'b111);
        push_item(8'hFF, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h5A, 1'b1);
        push_item(8'hFF, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'hFF, 1'b0);
        repeat (4) push_item(8'h00, 1'b1);
        drain();

        // Tall narrow frame with a mixed kernel.
        set_frame(2, 3);
        write_kernel(coef_word(), coef_word(), t_coef'(coef_word()), 3'b111);
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        push_item(8'h55, 1'b0);
        push_item(8'hAA, 1'b0);
        push_item(8'h0F, 1'b0);
        push_item(8'hF0, 1'b0);
        repeat (3) push_item(8'h00, 1'b1);
        drain();

        // Random frames, in three idle regimes; the last regime always gets its hold-off.
        while (random_items < RANDOM_BUDGET || !pressure_done) begin
            mode = (random_items < RANDOM_BUDGET / 3) ? 0 :
                   (random_items < 2 * RANDOM_BUDGET / 3) ? 1 : 2;
            case (mode)
                0: begin send_idle_pct = 18; recv_idle_pct = 69; end
                1: begin send_idle_pct = 69; recv_idle_pct = 18; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (mode == 2 && !pressure_done) begin
                // Long result hold while pixels keep coming, so the input stalls.
                pressure_done = 1'b1;
                set_frame(16, 4);
                hold_requests = hold_requests + 1;
                nframes = 1;
            end else begin
                set_frame(($urandom_range(7) == 0) ? $urandom_range(40, 13)
                                                   : $urandom_range(12, 1),
                          $urandom_range(6, 1));
                nframes = $urandom_range(3, 1);
            end
            write_kernel(coef_word(), coef_word(), t_coef'(coef_word()),
                         3'($urandom_range(7)));
            if ($urandom_range(7) == 0)
                write_reg(t_cfgidx'($urandom_range(2**CFG_IDX_W - 1,
                                                   int'(REG_COEF_C) + 1)),
                          {$urandom, $urandom});
            for (f = 0; f < nframes; f++) begin
                total = frame_w * (frame_h + 1) + 1;
                noisy = ($urandom_range(3) == 0);
                if (f == 0 && $urandom_range(5) == 0) begin
                    // Kernel change in the middle of a frame, once the block is quiet.
                    split = $urandom_range(total - 1, 1);
                    queue_items(frame_w, frame_h, 0, split, noisy);
                    drain();
                    write_kernel(coef_word(), coef_word(), t_coef'(coef_word()),
                                 3'(1 << $urandom_range(2)));
                    queue_items(frame_w, frame_h, split, total, noisy);
                end else begin
                    queue_items(frame_w, frame_h, 0, total, noisy);
                end
                random_items += total;
            end
            drain();
        end

        drain();
        $display("Covered %0d pixel transactions and %0d checked results in %0d frames,",
                 accepted_count, results_checked, frames_seen);
        $display("widths 1 to %0d under idle, stall and hold-off phases; %0d mismatches.",
                 widest_frame, mismatch_count);
        if (mismatch_count == 0 && expected_pixels.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
